/* src/llf_pkg.sv */
// Shared definitions for the longest line finder.
// Register indexes, search mode codes and output field widths.
// No dependencies.
package llf_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int COORD_W    = 10;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [COORD_W-1:0]    coord_t;

	localparam cfg_idx_t REG_SEARCH_MODE  = 2'd0;
	localparam cfg_idx_t REG_FRAME_WIDTH  = 2'd1;
	localparam cfg_idx_t REG_FRAME_HEIGHT = 2'd2;

	localparam logic MODE_HORIZ = 1'b0;
	localparam logic MODE_VERT  = 1'b1;

	localparam cfg_data_t FRAME_DIM_RESET = 11'd1024;

endpackage

/* src/llf_col_mem.sv */
// Column tracker memory for the longest line finder.
// One write port and one read port with registered read data.
// No dependencies.
module llf_col_mem #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 21
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* src/longest_line_finder.sv */
// Top level of the longest line finder.
// Depends on llf_pkg and llf_col_mem.
//
// Usage:
//   Pixels enter on in_valid/in_stall/pixel in row-major order, one per
//   cycle when not stalled. Frame size and search direction come from
//   the write port (cfg_we, cfg_index, cfg_data) and are to be written
//   between frames; the block does not enforce this.
//   After the last pixel of a frame one item leaves on out_valid/out_stall
//   with found, start/end coordinates and the length in pairs.
//   Throughput: one pixel per cycle when not stalled, set by the single
//   read-modify-write of the column memory per pixel (read on accept,
//   written from stage 1, bypassed for back-to-back pixels in a column).
//   Reset: counters, trackers and the best line clear at once; the column
//   memory is not swept, a fill count masks columns not yet written in
//   the current frame, so pixels are taken from the first cycle on.
//   Stall: while a result waits, pixels keep flowing; in_stall rises only
//   when a second end of frame reaches the output register still held.
module longest_line_finder
	import llf_pkg::*;
#(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  cfg_idx_t  cfg_index,
	input  cfg_data_t cfg_data,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic      pixel,
	output logic      out_valid,
	input  logic      out_stall,
	output logic      found,
	output coord_t    start_row,
	output coord_t    start_col,
	output coord_t    end_row,
	output coord_t    end_col,
	output coord_t    line_pairs
);

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int ROW_W  = $clog2(MAX_ROWS);
	localparam int PW     = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int FILL_W = COL_W + 1;
	localparam int SZ_A   = (COL_W + 1 > CFG_DATA_W) ? COL_W + 1 : CFG_DATA_W;
	localparam int SZ_W   = (ROW_W + 1 > SZ_A) ? ROW_W + 1 : SZ_A;
	localparam int ENT_W  = 1 + 2 * ROW_W;

	// configuration
	logic      mode_q;
	cfg_data_t width_q;
	cfg_data_t height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_HORIZ;
			width_q  <= FRAME_DIM_RESET;
			height_q <= FRAME_DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEARCH_MODE:  mode_q   <= cfg_data[0];
				REG_FRAME_WIDTH:  width_q  <= cfg_data;
				REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [SZ_W-1:0] w_eff, h_eff, w_raw, h_raw;

	always_comb begin
		w_raw = SZ_W'(width_q);
		h_raw = SZ_W'(height_q);
		if (w_raw == '0) w_eff = SZ_W'(1);
		else if (w_raw > SZ_W'(MAX_COLS)) w_eff = SZ_W'(MAX_COLS);
		else w_eff = w_raw;
		if (h_raw == '0) h_eff = SZ_W'(1);
		else if (h_raw > SZ_W'(MAX_ROWS)) h_eff = SZ_W'(MAX_ROWS);
		else h_eff = h_raw;
	end

	// input side: raster counters and fill count
	logic             accept;
	logic             v_s1, end_frame_s1;
	logic             s1_hold, s1_go;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [FILL_W-1:0] fill_q;
	logic             row_last, frame_last, col_ok;

	assign s1_hold  = v_s1 && end_frame_s1 && out_valid && out_stall;
	assign s1_go    = v_s1 && !s1_hold;
	assign in_stall = s1_hold;
	assign accept   = in_valid && !in_stall;

	assign row_last   = (SZ_W'(col_q) + SZ_W'(1)) >= w_eff;
	assign frame_last = row_last && ((SZ_W'(row_q) + SZ_W'(1)) >= h_eff);
	assign col_ok     = FILL_W'(col_q) < fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			fill_q <= '0;
		end else if (accept) begin
			if (frame_last) begin
				col_q  <= '0;
				row_q  <= '0;
				fill_q <= '0;
			end else begin
				if (row_last) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
				if (!col_ok) begin
					fill_q <= FILL_W'(col_q) + 1'b1;
				end
			end
		end
	end

	// stage 1 registers
	logic             px_s1, mode_s1, end_row_s1, col_ok_s1, byp_s1;
	logic [ROW_W-1:0] r_s1;
	logic [COL_W-1:0] c_s1;
	logic [ENT_W-1:0] byp_data_s1;
	logic [ENT_W-1:0] rd_data, ent, ent_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (s1_go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1        <= pixel;
			mode_s1      <= mode_q;
			r_s1         <= row_q;
			c_s1         <= col_q;
			end_row_s1   <= row_last;
			end_frame_s1 <= frame_last;
			col_ok_s1    <= col_ok;
			byp_s1       <= v_s1 && (c_s1 == col_q);
			byp_data_s1  <= ent_new;
		end
	end

	llf_col_mem #(
		.DEPTH  (MAX_COLS),
		.DATA_W (ENT_W)
	) u_col_mem (
		.clk   (clk),
		.we    (s1_go),
		.waddr (c_s1),
		.wdata (ent_new),
		.re    (accept),
		.raddr (col_q),
		.rdata (rd_data)
	);

	// stage 1 logic: vertical and horizontal trackers, best line
	logic             ent_prev, vhit, hhit;
	logic [ROW_W-1:0] ent_pairs, ent_start, v_pairs, v_start;
	logic [COL_W-1:0] h_pairs, h_start;

	logic             prev_row_q;
	logic [COL_W-1:0] row_pairs_q, row_start_q;
	logic             any_q;
	logic [PW-1:0]    best_q;
	logic [ROW_W-1:0] b_r0_q, b_r1_q;
	logic [COL_W-1:0] b_c0_q, b_c1_q;

	logic             h_better, v_better, nb_any;
	logic [PW-1:0]    nb_pairs;
	logic [ROW_W-1:0] nb_r0, nb_r1;
	logic [COL_W-1:0] nb_c0, nb_c1;

	always_comb begin
		if (byp_s1) ent = byp_data_s1;
		else if (col_ok_s1) ent = rd_data;
		else ent = '0;
		ent_prev  = ent[ENT_W-1];
		ent_pairs = ent[2*ROW_W-1:ROW_W];
		ent_start = ent[ROW_W-1:0];

		vhit    = (r_s1 != '0) && ent_prev && px_s1;
		v_start = (ent_pairs == '0) ? r_s1 - 1'b1 : ent_start;
		v_pairs = ent_pairs + 1'b1;
		ent_new = {px_s1, (vhit ? v_pairs : ROW_W'(0)), (vhit ? v_start : ent_start)};

		hhit    = (c_s1 != '0) && prev_row_q && px_s1;
		h_start = (row_pairs_q == '0) ? c_s1 - 1'b1 : row_start_q;
		h_pairs = row_pairs_q + 1'b1;

		h_better = (mode_s1 == MODE_HORIZ) && hhit && (PW'(h_pairs) > best_q);
		v_better = (mode_s1 == MODE_VERT) && vhit &&
			((PW'(v_pairs) > best_q) ||
			 ((PW'(v_pairs) == best_q) &&
			  ((v_start < b_r0_q) || ((v_start == b_r0_q) && (c_s1 < b_c0_q)))));

		nb_any   = any_q;
		nb_pairs = best_q;
		nb_r0    = b_r0_q;
		nb_c0    = b_c0_q;
		nb_r1    = b_r1_q;
		nb_c1    = b_c1_q;
		if (h_better) begin
			nb_any   = 1'b1;
			nb_pairs = PW'(h_pairs);
			nb_r0    = r_s1;
			nb_c0    = h_start;
			nb_r1    = r_s1;
			nb_c1    = c_s1;
		end else if (v_better) begin
			nb_any   = 1'b1;
			nb_pairs = PW'(v_pairs);
			nb_r0    = v_start;
			nb_c0    = c_s1;
			nb_r1    = r_s1;
			nb_c1    = c_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_row_q  <= 1'b0;
			row_pairs_q <= '0;
			row_start_q <= '0;
			any_q       <= 1'b0;
			best_q      <= '0;
			b_r0_q      <= '0;
			b_c0_q      <= '0;
			b_r1_q      <= '0;
			b_c1_q      <= '0;
		end else if (s1_go) begin
			if (end_frame_s1) begin
				prev_row_q  <= 1'b0;
				row_pairs_q <= '0;
				row_start_q <= '0;
				any_q       <= 1'b0;
				best_q      <= '0;
				b_r0_q      <= '0;
				b_c0_q      <= '0;
				b_r1_q      <= '0;
				b_c1_q      <= '0;
			end else begin
				if (end_row_s1) begin
					prev_row_q  <= 1'b0;
					row_pairs_q <= '0;
				end else begin
					prev_row_q  <= px_s1;
					row_pairs_q <= hhit ? h_pairs : COL_W'(0);
				end
				if (hhit) begin
					row_start_q <= h_start;
				end
				any_q  <= nb_any;
				best_q <= nb_pairs;
				b_r0_q <= nb_r0;
				b_c0_q <= nb_c0;
				b_r1_q <= nb_r1;
				b_c1_q <= nb_c1;
			end
		end
	end

	// result register
	logic out_load;

	assign out_load = s1_go && end_frame_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			found      <= nb_any;
			start_row  <= COORD_W'(nb_r0);
			start_col  <= COORD_W'(nb_c0);
			end_row    <= COORD_W'(nb_r1);
			end_col    <= COORD_W'(nb_c1);
			line_pairs <= COORD_W'(nb_pairs);
		end
	end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for longest_line_finder: streams bitmaps, predicts each frame's line.
// Depends on llf_pkg and the longest_line_finder RTL.
module tb_top;
	import llf_pkg::*;

	localparam int MAX_DIM     = 1024;
	localparam int CYCLE_LIMIT = 800000;
	localparam int PRINT_LIMIT = 50;

	typedef struct packed {
		logic   found;
		coord_t start_row;
		coord_t start_col;
		coord_t end_row;
		coord_t end_col;
		coord_t line_pairs;
	} line_t;

	logic      clk;
	logic      arst_n;
	logic      cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_data;
	logic      in_valid;
	logic      in_stall;
	logic      pixel;
	logic      out_valid;
	logic      out_stall;
	logic      found;
	coord_t    start_row;
	coord_t    start_col;
	coord_t    end_row;
	coord_t    end_col;
	coord_t    line_pairs;

	longest_line_finder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.found     (found),
		.start_row (start_row),
		.start_col (start_col),
		.end_row   (end_row),
		.end_col   (end_col),
		.line_pairs(line_pairs)
	);

	bit          pixel_feed [$];
	line_t       pending_lines [$];
	int unsigned queued_cnt;
	int unsigned taken_cnt;
	int unsigned error_cnt;
	int unsigned cycle_cnt;
	bit          px_taken;
	bit          bursts_on;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned rx_hold_left;

	logic        mode_sel;
	cfg_data_t   frame_w;
	cfg_data_t   frame_h;
	int unsigned row_cnt;
	int unsigned col_cnt;
	int unsigned run_pairs;
	int unsigned run_start;
	bit          prev_px;
	bit          col_prev [MAX_DIM];
	int unsigned col_pairs [MAX_DIM];
	int unsigned col_start [MAX_DIM];
	line_t       best_line;

	function automatic int unsigned eff_size(int unsigned v);
		if (v == 0)
			return 1;
		return (v > MAX_DIM) ? MAX_DIM : v;
	endfunction

	function automatic void clear_trackers();
		row_cnt   = 0;
		col_cnt   = 0;
		prev_px   = 0;
		run_pairs = 0;
		run_start = 0;
		foreach (col_prev[i]) begin
			col_prev[i]  = 0;
			col_pairs[i] = 0;
			col_start[i] = 0;
		end
		best_line = '0;
	endfunction

	function automatic void keep_line(int unsigned p, int unsigned r0, int unsigned c0,
			int unsigned r1, int unsigned c1);
		best_line.found      = 1'b1;
		best_line.line_pairs = coord_t'(p);
		best_line.start_row  = coord_t'(r0);
		best_line.start_col  = coord_t'(c0);
		best_line.end_row    = coord_t'(r1);
		best_line.end_col    = coord_t'(c1);
	endfunction

	function automatic void track_pixel(bit px);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		int unsigned p;
		int unsigned s;
		bit          row_end;
		w = eff_size(frame_w);
		h = eff_size(frame_h);
		r = row_cnt;
		c = col_cnt % MAX_DIM;
		if (c > 0 && prev_px && px) begin
			if (run_pairs == 0)
				run_start = c - 1;
			run_pairs++;
			if (mode_sel == MODE_HORIZ && run_pairs > best_line.line_pairs)
				keep_line(run_pairs, r, run_start, r, c);
		end else begin
			run_pairs = 0;
		end
		prev_px = px;
		if (r > 0 && col_prev[c] && px) begin
			if (col_pairs[c] == 0)
				col_start[c] = r - 1;
			col_pairs[c]++;
			p = col_pairs[c];
			s = col_start[c];
			if (mode_sel == MODE_VERT && (p > best_line.line_pairs ||
					(p == best_line.line_pairs && (s < best_line.start_row ||
					(s == best_line.start_row && c < best_line.start_col)))))
				keep_line(p, s, c, r, c);
		end else begin
			col_pairs[c] = 0;
		end
		col_prev[c] = px;
		row_end = (col_cnt + 1 >= w);
		if (row_end && row_cnt + 1 >= h) begin
			pending_lines.push_back(best_line);
			clear_trackers();
		end else if (row_end) begin
			col_cnt   = 0;
			row_cnt++;
			prev_px   = 0;
			run_pairs = 0;
		end else begin
			col_cnt++;
		end
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		if (error_cnt < PRINT_LIMIT)
			$display("tb_top: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
		error_cnt++;
	endtask

	task automatic set_reg(cfg_idx_t idx, int unsigned value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= cfg_data_t'(value);
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			REG_SEARCH_MODE:  mode_sel = value[0];
			REG_FRAME_WIDTH:  frame_w  = cfg_data_t'(value);
			REG_FRAME_HEIGHT: frame_h  = cfg_data_t'(value);
			default: ;
		endcase
	endtask

	task automatic send_bits(logic [31:0] pattern, int n);
		for (int i = n - 1; i >= 0; i--) begin
			pixel_feed.push_back(pattern[i]);
			queued_cnt++;
		end
	endtask

	task automatic send_random(int unsigned n, int unsigned pct);
		repeat (n) begin
			pixel_feed.push_back($urandom_range(0, 99) < pct);
			queued_cnt++;
		end
	endtask

	task automatic drain();
		while (!(taken_cnt == queued_cnt && pending_lines.size() == 0))
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic int unsigned pick_dim();
		case ($urandom_range(0, 15))
			0:       return 0;
			1:       return $urandom_range(9, 16);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	task automatic random_phase();
		int unsigned w;
		int unsigned h;
		int unsigned n;
		set_reg(REG_SEARCH_MODE, $urandom_range(0, 1));
		if ($urandom_range(0, 3) != 0)
			set_reg(REG_FRAME_WIDTH, pick_dim());
		if ($urandom_range(0, 3) != 0)
			set_reg(REG_FRAME_HEIGHT, pick_dim());
		w = eff_size(frame_w);
		h = eff_size(frame_h);
		n = (w * h > 64) ? w * h : $urandom_range(1, 4) * w * h;
		// leave a partial frame so the next settings land mid-frame
		if ($urandom_range(0, 3) == 0)
			n += $urandom_range(1, w * h);
		send_random(n, $urandom_range(0, 4) * 25);
		drain();
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// take pixel and predict
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			track_pixel(pixel);
			taken_cnt++;
			px_taken = 1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || px_taken) begin
			px_taken = 0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (pixel_feed.size() > 0) begin
				if (bursts_on && $urandom_range(0, 15) == 0) begin
					gap_left = $urandom_range(0, 8);
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					pixel    <= pixel_feed.pop_front();
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (bursts_on && $urandom_range(0, 11) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		line_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_lines.size() == 0) begin
				report_mismatch("unexpected result, found", found, 0);
			end else begin
				want = pending_lines.pop_front();
				if (found !== want.found)
					report_mismatch("found", found, want.found);
				if (start_row !== want.start_row)
					report_mismatch("start_row", start_row, want.start_row);
				if (start_col !== want.start_col)
					report_mismatch("start_col", start_col, want.start_col);
				if (end_row !== want.end_row)
					report_mismatch("end_row", end_row, want.end_row);
				if (end_col !== want.end_col)
					report_mismatch("end_col", end_col, want.end_col);
				if (line_pairs !== want.line_pairs)
					report_mismatch("line_pairs", line_pairs, want.line_pairs);
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_SEARCH_MODE;
		cfg_data     = '0;
		in_valid     = 1'b0;
		pixel        = 1'b0;
		out_stall    = 1'b0;
		bursts_on    = 1;
		queued_cnt   = 0;
		taken_cnt    = 0;
		error_cnt    = 0;
		cycle_cnt    = 0;
		gap_left     = 0;
		stall_left   = 0;
		rx_hold_left = 0;
		px_taken     = 0;
		mode_sel     = MODE_HORIZ;
		frame_w      = FRAME_DIM_RESET;
		frame_h      = FRAME_DIM_RESET;
		clear_trackers();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;

		// horizontal tie: first run in raster order wins
		set_reg(REG_SEARCH_MODE, MODE_HORIZ);
		set_reg(REG_FRAME_WIDTH, 4);
		set_reg(REG_FRAME_HEIGHT, 2);
		send_bits(32'b1100_0011, 8);
		drain();
		// vertical tie on start row: leftmost column wins
		set_reg(REG_SEARCH_MODE, MODE_VERT);
		set_reg(REG_FRAME_WIDTH, 3);
		set_reg(REG_FRAME_HEIGHT, 3);
		send_bits(32'b011_111_100, 9);
		drain();
		// lone set pixel is no line
		set_reg(REG_SEARCH_MODE, MODE_HORIZ);
		set_reg(REG_FRAME_WIDTH, 2);
		set_reg(REG_FRAME_HEIGHT, 2);
		send_bits(32'b0100, 4);
		drain();

		// oversize width clamps to the widest frame
		set_reg(REG_FRAME_WIDTH, 2047);
		set_reg(REG_FRAME_HEIGHT, 1);
		send_random(MAX_DIM, 100);
		drain();

		// oversize settings, then shrink mid-frame
		send_random(60, 75);
		drain();
		set_reg(REG_FRAME_WIDTH, 3);
		send_random(7, 50);
		drain();
		set_reg(REG_SEARCH_MODE, MODE_VERT);
		set_reg(REG_FRAME_WIDTH, 1);
		set_reg(REG_FRAME_HEIGHT, 2047);
		send_random(60, 75);
		drain();
		set_reg(REG_FRAME_HEIGHT, 4);
		send_random(5, 50);
		drain();

		// hold the output long enough for the input to back up
		set_reg(REG_SEARCH_MODE, $urandom_range(0, 1));
		set_reg(REG_FRAME_WIDTH, 2);
		set_reg(REG_FRAME_HEIGHT, 2);
		rx_hold_left = 200;
		send_random(48, 50);
		drain();

		while (queued_cnt < 1300)
			random_phase();
		bursts_on = 0;
		repeat (4) random_phase();

		if (error_cnt == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

/* filelist.f */
src/llf_pkg.sv
src/llf_col_mem.sv
src/longest_line_finder.sv
dv/tb_top.sv
